// ----- rtl/mimms_pkg.sv -----
// shared types, constants and helper functions for the min / max / sum reduction
package mimms_pkg;

   localparam int DATA_WIDTH          = 64;
   localparam int NULL_OUT_WIDTH      = 32;
   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int CSR_DATA_WIDTH      = 2;

   localparam logic [DATA_WIDTH-1:0] SIGN_BIAS = 64'h8000_0000_0000_0000;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ELEM_WIDTH_MODE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIGNED_MODE     = 2'd1;

   typedef enum logic [1:0] {
      WIDTH_8  = 2'd0,
      WIDTH_16 = 2'd1,
      WIDTH_32 = 2'd2,
      WIDTH_64 = 2'd3
   } width_mode_type;

   typedef struct packed {
      width_mode_type elem_width_mode;
      logic           signed_mode;
   } cfg_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] element_value;
      logic                  element_valid;
      logic                  last_element;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0]     min_value;
      logic [DATA_WIDTH-1:0]     max_value;
      logic [DATA_WIDTH-1:0]     sum_value;
      logic [NULL_OUT_WIDTH-1:0] null_count;
   } rsp_type;

   // classified request: value already extended to full width
   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      logic                  participates;
      logic                  last_element;
   } op_type;

   function automatic logic [DATA_WIDTH-1:0] width_mask(input width_mode_type mode);
      logic [DATA_WIDTH-1:0] mask;
      unique case (mode)
         WIDTH_8:  mask = 64'h0000_0000_0000_00FF;
         WIDTH_16: mask = 64'h0000_0000_0000_FFFF;
         WIDTH_32: mask = 64'h0000_0000_FFFF_FFFF;
         WIDTH_64: mask = 64'hFFFF_FFFF_FFFF_FFFF;
         default:  mask = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return mask;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] type_max(input cfg_type cfg);
      logic [DATA_WIDTH-1:0] mask;
      mask = width_mask(cfg.elem_width_mode);
      return cfg.signed_mode ? (mask >> 1) : mask;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] type_lowest(input cfg_type cfg);
      logic [DATA_WIDTH-1:0] mask;
      mask = width_mask(cfg.elem_width_mode);
      return cfg.signed_mode ? ~(mask >> 1) : '0;
   endfunction

endpackage

// ----- rtl/masked_int_reduce_min_max_sum.sv -----
// top level of the null-aware min / max / sum column reduction
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data (element, valid, last)
//   rsp      out        rsp_valid / rsp_ready  rsp_data (min, max, sum, null count)
//   csr      in         csr_write_en           csr_index, csr_wdata
//
// one request per cycle sustained while nothing stalls; a request passes the front
// register, the queue and the back accumulator, where its result is registered
// reset clears the accumulators and sets 64-bit signed mode; no clearing pass
// a stalled result holds the back stage only on a last request; the queue and
// front register keep taking requests until full
module masked_int_reduce_min_max_sum #(
   parameter int COUNT_WIDTH = mimms_pkg::COUNT_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = mimms_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  mimms_pkg::req_type                       req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output mimms_pkg::rsp_type                       rsp_data,
   input  logic                                     csr_write_en,
   input  logic [mimms_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [mimms_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import mimms_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    cfg_clear;
   logic    front_valid;
   logic    front_ready;
   op_type  front_data;
   logic    back_valid;
   logic    back_ready;
   op_type  back_data;

   assign cfg_clear = csr_write_en &&
                      ((csr_index == CSR_ELEM_WIDTH_MODE) || (csr_index == CSR_SIGNED_MODE));

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         if (csr_index == CSR_ELEM_WIDTH_MODE) begin
            cfg_in.elem_width_mode = width_mode_type'(csr_wdata[1:0]);
         end else if (csr_index == CSR_SIGNED_MODE) begin
            cfg_in.signed_mode = csr_wdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.elem_width_mode <= WIDTH_64;
         cfg_ff.signed_mode     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mimms_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .op_valid  (front_valid),
      .op_ready  (front_ready),
      .op_data   (front_data)
   );

   mimms_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_data)
   );

   mimms_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cfg_clear (cfg_clear),
      .op_valid  (back_valid),
      .op_ready  (back_ready),
      .op_data   (back_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/mimms_front.sv -----
// front stage: accepts requests, masks and extends the element, registers the classified op
module mimms_front (
   input  logic               clock,
   input  logic               reset,
   input  mimms_pkg::cfg_type cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  mimms_pkg::req_type req_data,
   output logic               op_valid,
   input  logic               op_ready,
   output mimms_pkg::op_type  op_data
);
   import mimms_pkg::*;

   logic                  valid_ff;
   logic                  valid_in;
   op_type                op_ff;
   op_type                op_in;
   logic [DATA_WIDTH-1:0] mask;
   logic [DATA_WIDTH-1:0] masked;
   logic                  accept;

   assign req_ready = !valid_ff || op_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      mask   = width_mask(cfg.elem_width_mode);
      masked = req_data.element_value & mask;
      op_in.value = masked;
      if (cfg.signed_mode && (|(masked & ~(mask >> 1)))) begin
         op_in.value = masked | ~mask;
      end
      op_in.participates = req_data.element_valid;
      op_in.last_element = req_data.last_element;
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (op_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= op_in;
      end
   end

   assign op_valid = valid_ff;
   assign op_data  = op_ff;

endmodule

// ----- rtl/mimms_queue.sv -----
// short fifo of classified ops between the front and back stages
module mimms_queue #(
   parameter int DEPTH = mimms_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  mimms_pkg::op_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output mimms_pkg::op_type pop_data
);
   import mimms_pkg::*;

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   op_type                 mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [PTR_WIDTH-1:0]   wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [PTR_WIDTH-1:0]   rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = (count_ff != COUNT_WIDTH'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/mimms_back.sv -----
// back stage: running min, max, sum and null count, with the registered result
module mimms_back #(
   parameter int COUNT_WIDTH = mimms_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  mimms_pkg::cfg_type cfg,
   input  logic               cfg_clear,
   input  logic               op_valid,
   output logic               op_ready,
   input  mimms_pkg::op_type  op_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mimms_pkg::rsp_type rsp_data
);
   import mimms_pkg::*;

   logic                      empty_ff;
   logic                      empty_in;
   logic [DATA_WIDTH-1:0]     min_ff;
   logic [DATA_WIDTH-1:0]     min_in;
   logic [DATA_WIDTH-1:0]     max_ff;
   logic [DATA_WIDTH-1:0]     max_in;
   logic [DATA_WIDTH-1:0]     sum_ff;
   logic [DATA_WIDTH-1:0]     sum_in;
   logic [COUNT_WIDTH-1:0]    cnt_ff;
   logic [COUNT_WIDTH-1:0]    cnt_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   rsp_type                   rsp_data_ff;
   rsp_type                   rsp_data_in;
   logic                      fold_empty;
   logic [DATA_WIDTH-1:0]     fold_min;
   logic [DATA_WIDTH-1:0]     fold_max;
   logic [DATA_WIDTH-1:0]     fold_sum;
   logic [COUNT_WIDTH-1:0]    fold_cnt;
   logic [NULL_OUT_WIDTH-1:0] null_out;
   logic                      pop;

   function automatic logic less_than(input logic [DATA_WIDTH-1:0] a,
                                      input logic [DATA_WIDTH-1:0] b,
                                      input logic                  sgn);
      return sgn ? ((a ^ SIGN_BIAS) < (b ^ SIGN_BIAS)) : (a < b);
   endfunction

   // result slot must be free or draining before a last op is taken
   assign op_ready = !op_data.last_element || !rsp_valid_ff || rsp_ready;
   assign pop      = op_valid && op_ready;

   // fold the current op into the accumulators
   always_comb begin
      fold_empty = empty_ff;
      fold_min   = min_ff;
      fold_max   = max_ff;
      fold_sum   = sum_ff;
      fold_cnt   = cnt_ff;
      if (op_data.participates) begin
         fold_empty = 1'b0;
         fold_sum   = sum_ff + op_data.value;
         if (empty_ff || less_than(op_data.value, min_ff, cfg.signed_mode)) begin
            fold_min = op_data.value;
         end
         if (empty_ff || less_than(max_ff, op_data.value, cfg.signed_mode)) begin
            fold_max = op_data.value;
         end
      end else if (cnt_ff != '1) begin
         fold_cnt = cnt_ff + 1'b1;
      end
   end

   generate
      if (COUNT_WIDTH > NULL_OUT_WIDTH) begin : g_null_sat
         assign null_out = (|fold_cnt[COUNT_WIDTH-1:NULL_OUT_WIDTH]) ?
                           '1 : fold_cnt[NULL_OUT_WIDTH-1:0];
      end else begin : g_null_ext
         assign null_out = NULL_OUT_WIDTH'(fold_cnt);
      end
   endgenerate

   always_comb begin
      empty_in     = empty_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      rsp_data_in.min_value  = fold_empty ? type_max(cfg) : fold_min;
      rsp_data_in.max_value  = fold_empty ? type_lowest(cfg) : fold_max;
      rsp_data_in.sum_value  = fold_sum;
      rsp_data_in.null_count = null_out;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cfg_clear) begin
         empty_in = 1'b1;
         sum_in   = '0;
         cnt_in   = '0;
      end else if (pop) begin
         if (op_data.last_element) begin
            empty_in     = 1'b1;
            sum_in       = '0;
            cnt_in       = '0;
            rsp_valid_in = 1'b1;
         end else begin
            empty_in = fold_empty;
            min_in   = fold_min;
            max_in   = fold_max;
            sum_in   = fold_sum;
            cnt_in   = fold_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff     <= 1'b1;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         empty_ff     <= empty_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff <= min_in;
      max_ff <= max_in;
      if (pop && op_data.last_element) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
